// ===== src/hmp_tep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_tep_pkg
// Shared types and constants of the HMP track event parser: item structs,
// record kinds, parse phases and the status and meta codes.
// ----------------------------------------------------------------------------
package hmp_tep_pkg;

  // Default width of the running timestamp.
  localparam int TIME_WIDTH_DEF = 32;

  // Status and meta codes.
  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [3:0] NIB_PROGRAM    = 4'hC;
  localparam logic [3:0] NIB_PRESSURE   = 4'hD;
  localparam logic [3:0] NIB_SYSTEM     = 4'hF;

  // Group counters.
  localparam logic [2:0] LEN_GROUPS_MAX   = 3'd4;
  localparam logic [2:0] DELTA_GROUPS_MAX = 3'd7;

  // Data byte counts of channel events.
  localparam logic [1:0] DATA_ONE = 2'd1;
  localparam logic [1:0] DATA_TWO = 2'd2;

  typedef enum logic [1:0] {
    REC_CHANNEL   = 2'd0,
    REC_META_HDR  = 2'd1,
    REC_META_DATA = 2'd2,
    REC_ERROR     = 2'd3
  } rec_kind_t;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_MLEN   = 3'd5,
    PH_MDATA  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       track_start;
    logic       track_end;
  } in_item_t;

  typedef struct packed {
    rec_kind_t   record_kind;
    logic [31:0] event_time;
    logic [2:0]  status_class;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [27:0] meta_length;
    logic        last_of_track;
  } out_item_t;

endpackage

// ===== src/hmp_tep_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_tep_time
// Delta-time accumulator and running timestamp. Collects the 7-bit delta
// groups, least significant first, and adds the delta to the timestamp on
// the byte that closes it.
// ----------------------------------------------------------------------------
module hmp_tep_time #(
  parameter int TIME_WIDTH = hmp_tep_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  start,
  input  logic                  in_delta,
  input  logic [7:0]            byte_in,
  output logic [TIME_WIDTH-1:0] time_now,
  output logic                  delta_idle
);

  logic [TIME_WIDTH-1:0] time_r, time_nxt;
  logic [31:0]           sum_r, sum_nxt;
  logic [2:0]            cnt_r, cnt_nxt;

  logic [TIME_WIDTH-1:0] time_base;
  logic [31:0]           sum_base;
  logic [2:0]            cnt_base;
  logic [31:0]           group_val;
  logic [31:0]           sum_add;

  assign time_base = start ? '0 : time_r;
  assign sum_base  = start ? '0 : sum_r;
  assign cnt_base  = start ? '0 : cnt_r;

  // Groups that would land at bit 32 or above are dropped.
  always_comb begin
    case (cnt_base)
      3'd0:    group_val = {25'd0, byte_in[6:0]};
      3'd1:    group_val = {18'd0, byte_in[6:0], 7'd0};
      3'd2:    group_val = {11'd0, byte_in[6:0], 14'd0};
      3'd3:    group_val = {4'd0, byte_in[6:0], 21'd0};
      3'd4:    group_val = {byte_in[3:0], 28'd0};
      default: group_val = 32'd0;
    endcase
  end

  assign sum_add = sum_base + group_val;

  always_comb begin
    time_nxt = time_base;
    sum_nxt  = sum_base;
    cnt_nxt  = cnt_base;
    if (in_delta) begin
      sum_nxt = sum_add;
      cnt_nxt = (cnt_base != hmp_tep_pkg::DELTA_GROUPS_MAX) ? cnt_base + 3'd1 : cnt_base;
      if (byte_in[7]) begin
        time_nxt = time_base + TIME_WIDTH'(sum_add);
        sum_nxt  = '0;
        cnt_nxt  = '0;
      end
    end
  end

  assign time_now   = time_nxt;
  assign delta_idle = (cnt_nxt == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      time_r <= time_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // A closing delta byte leaves the accumulator empty.
  a_delta_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_delta && byte_in[7] |=> (cnt_r == 3'd0) && (sum_r == 32'd0))
    else $error("delta accumulator not cleared after closing byte");

endmodule

// ===== src/hmp_tep_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_tep_parse
// Event state machine. Walks status, data, meta type, meta count and meta
// payload bytes and builds at most one record per body byte.
// ----------------------------------------------------------------------------
module hmp_tep_parse #(
  parameter int TIME_WIDTH = hmp_tep_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  hmp_tep_pkg::in_item_t  item,
  input  logic [TIME_WIDTH-1:0]  time_now,
  input  logic                   delta_idle,
  output logic                   in_delta,
  output logic                   rec_valid,
  output hmp_tep_pkg::out_item_t rec
);

  hmp_tep_pkg::phase_t phase_r, phase_nxt, phase_base;
  logic [7:0]  status_r, status_nxt, status_base;
  logic [7:0]  data_r, data_nxt, data_base;
  logic [7:0]  mtype_r, mtype_nxt, mtype_base;
  logic [27:0] mleft_r, mleft_nxt, mleft_base;
  logic [2:0]  lcnt_r, lcnt_nxt, lcnt_base;

  logic [7:0]  b;
  logic [63:0] time_ext;
  logic [2:0]  lcnt_inc;
  logic [27:0] mleft_shift;
  logic [27:0] mleft_dec;
  logic        meta_is_end;

  function automatic hmp_tep_pkg::out_item_t err_rec(input logic [31:0] t,
                                                     input logic [7:0] bad);
    hmp_tep_pkg::out_item_t r;
    r               = '0;
    r.record_kind   = hmp_tep_pkg::REC_ERROR;
    r.event_time    = t;
    r.first_data    = bad;
    r.last_of_track = 1'b1;
    return r;
  endfunction

  assign b           = item.body_byte;
  assign time_ext    = 64'(time_now);
  assign phase_base  = item.track_start ? hmp_tep_pkg::PH_DELTA : phase_r;
  assign status_base = item.track_start ? 8'd0 : status_r;
  assign data_base   = item.track_start ? 8'd0 : data_r;
  assign mtype_base  = item.track_start ? 8'd0 : mtype_r;
  assign mleft_base  = item.track_start ? 28'd0 : mleft_r;
  assign lcnt_base   = item.track_start ? 3'd0 : lcnt_r;
  assign in_delta    = (phase_base == hmp_tep_pkg::PH_DELTA);

  assign lcnt_inc    = lcnt_base + 3'd1;
  assign mleft_shift = {mleft_base[20:0], b[6:0]};
  assign mleft_dec   = mleft_base - 28'd1;
  assign meta_is_end = (mtype_base == hmp_tep_pkg::META_END_TRACK);

  always_comb begin
    phase_nxt  = phase_base;
    status_nxt = status_base;
    data_nxt   = data_base;
    mtype_nxt  = mtype_base;
    mleft_nxt  = mleft_base;
    lcnt_nxt   = lcnt_base;
    rec_valid  = 1'b0;
    rec        = '0;
    rec.event_time = time_ext[31:0];

    case (phase_base)
      hmp_tep_pkg::PH_DELTA: begin
        if (b[7]) begin
          phase_nxt = hmp_tep_pkg::PH_STATUS;
        end
      end
      hmp_tep_pkg::PH_STATUS: begin
        if (b == hmp_tep_pkg::STATUS_META) begin
          phase_nxt = hmp_tep_pkg::PH_MTYPE;
        end else if (b[7] && (b[7:4] != hmp_tep_pkg::NIB_SYSTEM)) begin
          status_nxt = b;
          phase_nxt  = hmp_tep_pkg::PH_DATA1;
        end else begin
          rec_valid = 1'b1;
          rec       = err_rec(time_ext[31:0], b);
          phase_nxt = hmp_tep_pkg::PH_DONE;
        end
      end
      hmp_tep_pkg::PH_DATA1: begin
        if ((status_base[7:4] == hmp_tep_pkg::NIB_PROGRAM) ||
            (status_base[7:4] == hmp_tep_pkg::NIB_PRESSURE)) begin
          rec_valid        = 1'b1;
          rec.record_kind  = hmp_tep_pkg::REC_CHANNEL;
          rec.status_class = status_base[6:4];
          rec.channel      = status_base[3:0];
          rec.first_data   = b;
          rec.data_count   = hmp_tep_pkg::DATA_ONE;
          phase_nxt        = hmp_tep_pkg::PH_DELTA;
        end else begin
          data_nxt  = b;
          phase_nxt = hmp_tep_pkg::PH_DATA2;
        end
      end
      hmp_tep_pkg::PH_DATA2: begin
        rec_valid        = 1'b1;
        rec.record_kind  = hmp_tep_pkg::REC_CHANNEL;
        rec.status_class = status_base[6:4];
        rec.channel      = status_base[3:0];
        rec.first_data   = data_base;
        rec.second_data  = b;
        rec.data_count   = hmp_tep_pkg::DATA_TWO;
        phase_nxt        = hmp_tep_pkg::PH_DELTA;
      end
      hmp_tep_pkg::PH_MTYPE: begin
        mtype_nxt = b;
        mleft_nxt = '0;
        lcnt_nxt  = '0;
        phase_nxt = hmp_tep_pkg::PH_MLEN;
      end
      hmp_tep_pkg::PH_MLEN: begin
        mleft_nxt = mleft_shift;
        lcnt_nxt  = lcnt_inc;
        if (b[7]) begin
          if (lcnt_inc >= hmp_tep_pkg::LEN_GROUPS_MAX) begin
            rec_valid = 1'b1;
            rec       = err_rec(time_ext[31:0], b);
            phase_nxt = hmp_tep_pkg::PH_DONE;
          end
        end else begin
          rec_valid       = 1'b1;
          rec.record_kind = hmp_tep_pkg::REC_META_HDR;
          rec.first_data  = mtype_base;
          rec.meta_length = mleft_shift;
          if (mleft_shift == 28'd0) begin
            rec.last_of_track = meta_is_end;
            phase_nxt = meta_is_end ? hmp_tep_pkg::PH_DONE : hmp_tep_pkg::PH_DELTA;
          end else begin
            phase_nxt = hmp_tep_pkg::PH_MDATA;
          end
        end
      end
      hmp_tep_pkg::PH_MDATA: begin
        mleft_nxt       = mleft_dec;
        rec_valid       = 1'b1;
        rec.record_kind = hmp_tep_pkg::REC_META_DATA;
        rec.first_data  = b;
        rec.meta_length = mleft_dec;
        if (mleft_dec == 28'd0) begin
          rec.last_of_track = meta_is_end;
          phase_nxt = meta_is_end ? hmp_tep_pkg::PH_DONE : hmp_tep_pkg::PH_DELTA;
        end
      end
      default: begin
        phase_nxt = hmp_tep_pkg::PH_DONE;
      end
    endcase

    // The last body byte closes the track. If it leaves an event open, its
    // record becomes an error record.
    if (item.track_end && (phase_nxt != hmp_tep_pkg::PH_DONE)) begin
      if ((phase_nxt == hmp_tep_pkg::PH_DELTA) && delta_idle) begin
        rec.last_of_track = rec_valid;
      end else begin
        rec_valid = 1'b1;
        rec       = err_rec(time_ext[31:0], b);
      end
      phase_nxt = hmp_tep_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hmp_tep_pkg::PH_DELTA;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      data_r   <= '0;
      mtype_r  <= '0;
      mleft_r  <= '0;
      lcnt_r   <= '0;
    end else if (step) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      mtype_r  <= mtype_nxt;
      mleft_r  <= mleft_nxt;
      lcnt_r   <= lcnt_nxt;
    end
  end

  // Once the track is closed, only a new track start brings records again.
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hmp_tep_pkg::PH_DONE) && !item.track_start |-> !rec_valid)
    else $error("record produced after the track was closed");

  // Every error record closes the track.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid && (rec.record_kind == hmp_tep_pkg::REC_ERROR) |->
      rec.last_of_track && (phase_nxt == hmp_tep_pkg::PH_DONE))
    else $error("error record does not close the track");

  // The payload phase always has at least one byte left to come.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hmp_tep_pkg::PH_MDATA) |-> (mleft_r != 28'd0))
    else $error("payload phase entered with nothing left");

endmodule

// ===== src/hmp_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_track_event_parser
// Parses an HMP track body one byte per transaction and delivers channel
// events, meta headers, meta payload bytes and format errors as records.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_*      input      in_valid / in_stall   hmp_tep_pkg::in_item_t
//   out_*     output     out_valid / out_stall hmp_tep_pkg::out_item_t
//
// Each body byte is captured in an input register, parsed by combinational
// logic and, if it makes a record, written to the result register, so a
// record passes the input register and then the result register.
// One byte is taken every cycle while the output is not stalled; the state
// update of the parse state machine and the timestamp adder sets that rate.
// A stall on the output holds the result register and, through it, the
// input register; in_stall rises only while the input register is occupied
// and cannot move on.
// Reset is synchronous and active low and leaves the parser waiting for the
// first delta byte with a zero timestamp.
// ----------------------------------------------------------------------------
module hmp_track_event_parser #(
  parameter int TIME_WIDTH = hmp_tep_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  hmp_tep_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output hmp_tep_pkg::out_item_t out_item
);

  // Input register stage.
  logic                  s1_valid_r, s1_valid_nxt;
  hmp_tep_pkg::in_item_t s1_item_r;

  // Result register stage.
  logic                   out_valid_r, out_valid_nxt;
  hmp_tep_pkg::out_item_t out_item_r;

  logic                   advance;
  logic                   in_take;
  logic                   in_delta;
  logic                   delta_idle;
  logic [TIME_WIDTH-1:0]  time_now;
  logic                   rec_valid;
  hmp_tep_pkg::out_item_t rec;

  // The byte in the input register is parsed when the result register is
  // empty or is being emptied in this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hmp_tep_time #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_time (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .start      (s1_item_r.track_start),
    .in_delta   (in_delta),
    .byte_in    (s1_item_r.body_byte),
    .time_now   (time_now),
    .delta_idle (delta_idle)
  );

  hmp_tep_parse #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (s1_item_r),
    .time_now   (time_now),
    .delta_idle (delta_idle),
    .in_delta   (in_delta),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = rec_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance && rec_valid) begin
      out_item_r <= rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Input is held back only while a byte waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty input register");

endmodule
